// ----- rtl/ppmdl_pkg.sv -----
// ----------------------------------------------------------------------------
// ppmdl_pkg
// Shared types and constants of the pressure-pad motor drive limiter.
// ----------------------------------------------------------------------------
package ppmdl_pkg;

    localparam int ADC_W  = 12;
    localparam int DUTY_W = 15;
    localparam int CMP_W  = 9;
    localparam int CFG_W  = 15;
    localparam int IDX_W  = 3;

    typedef logic [ADC_W-1:0]  t_adc;
    typedef logic [DUTY_W-1:0] t_duty;
    typedef logic [CMP_W-1:0]  t_cmp;
    typedef logic [1:0]        t_reason;
    typedef logic [IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_W-1:0]  t_cfg_data;

    localparam t_adc  ADC_FULL  = 12'd4095;
    localparam t_duty DUTY_FULL = 15'd25600;

    localparam t_cfg_idx REG_LOWER_LIMIT       = 3'd0;
    localparam t_cfg_idx REG_UPPER_LIMIT       = 3'd1;
    localparam t_cfg_idx REG_PAD_DEADZONE      = 3'd2;
    localparam t_cfg_idx REG_OTHER_PAD_IDLE    = 3'd3;
    localparam t_cfg_idx REG_OVERCURRENT_LEVEL = 3'd4;
    localparam t_cfg_idx REG_MAX_DUTY          = 3'd5;
    localparam t_cfg_idx REG_RAMP_STEP         = 3'd6;
    localparam t_cfg_idx REG_MIN_COMMAND       = 3'd7;

    localparam t_adc  RST_LOWER_LIMIT       = 12'd600;
    localparam t_adc  RST_UPPER_LIMIT       = 12'd3500;
    localparam t_adc  RST_PAD_DEADZONE      = 12'd200;
    localparam t_adc  RST_OTHER_PAD_IDLE    = 12'd100;
    localparam t_adc  RST_OVERCURRENT_LEVEL = 12'd805;
    localparam t_duty RST_MAX_DUTY          = 15'd12800;
    localparam t_duty RST_RAMP_STEP         = 15'd512;
    localparam t_duty RST_MIN_COMMAND       = 15'd128;

    localparam t_reason STOP_NONE        = 2'd0;
    localparam t_reason STOP_UPPER       = 2'd1;
    localparam t_reason STOP_LOWER       = 2'd2;
    localparam t_reason STOP_OVERCURRENT = 2'd3;

endpackage

// ----- rtl/ppmdl_if.sv -----
// ----------------------------------------------------------------------------
// ppmdl_if
// Sample and result channels of the pressure-pad motor drive limiter.
// ----------------------------------------------------------------------------
interface ppmdl_in_if;
    import ppmdl_pkg::*;

    logic valid;
    logic ready;
    t_adc up_pressure;
    t_adc down_pressure;
    t_adc arm_position;
    t_adc motor_current;

    modport source (
        output valid, up_pressure, down_pressure, arm_position, motor_current,
        input  ready
    );
    modport sink (
        input  valid, up_pressure, down_pressure, arm_position, motor_current,
        output ready
    );
endinterface

interface ppmdl_out_if;
    import ppmdl_pkg::*;

    logic    valid;
    logic    ready;
    logic    drive_up;
    logic    drive_down;
    t_duty   duty_level;
    t_cmp    pwm_compare;
    t_reason stop_reason;

    modport source (
        output valid, drive_up, drive_down, duty_level, pwm_compare, stop_reason,
        input  ready
    );
    modport sink (
        input  valid, drive_up, drive_down, duty_level, pwm_compare, stop_reason,
        output ready
    );
endinterface

// ----- rtl/pressure_pad_motor_drive_limiter.sv -----
// ----------------------------------------------------------------------------
// pressure_pad_motor_drive_limiter
// Turns pad, position and current samples into a bridge direction, a ramped
// duty in Q8 percent, a PWM compare value and a stop reason.
// ----------------------------------------------------------------------------
// One sample beat is taken at a time and yields one result beat. Between
// accept and result valid, B being the bit width of PWM_PERIOD_TICKS, two
// bit-serial lanes form both pad commands over 15 multiply and 15 divide
// steps, the arbitration state arbitrates and ramps, and a third lane forms
// the compare value over B multiply and B divide steps. A finished result
// waits in the output register while the next sample beat is accepted.
// Configuration writes belong to idle periods.
module pressure_pad_motor_drive_limiter #(
    parameter int PWM_PERIOD_TICKS = 500
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ppmdl_in_if.sink              i_in,
    ppmdl_out_if.source           o_out,
    input  logic                  i_cfg_we,
    input  ppmdl_pkg::t_cfg_idx   i_cfg_idx,
    input  ppmdl_pkg::t_cfg_data  i_cfg_data
);
    import ppmdl_pkg::*;

    localparam int PERW = $clog2(PWM_PERIOD_TICKS + 1);

    typedef enum logic [2:0] {S_IDLE, S_CMD, S_ARB, S_PWM, S_WAIT} t_state;

    t_state  r_state;
    logic    r_pad_start;
    logic    r_cmp_start;

    t_adc    r_lower_limit;
    t_adc    r_upper_limit;
    t_adc    r_pad_deadzone;
    t_adc    r_other_pad_idle;
    t_adc    r_overcurrent_level;
    t_duty   r_max_duty;
    t_duty   r_ramp_step;
    t_duty   r_min_command;

    t_adc    r_up_raw;
    t_adc    r_dn_raw;
    t_adc    r_pos;
    t_adc    r_cur;
    t_adc    r_up_diff;
    t_adc    r_dn_diff;

    t_duty   r_held_duty;
    t_duty   r_duty;
    logic    r_go_up;
    logic    r_go_down;
    t_reason r_reason;

    logic    r_out_valid;
    logic    r_out_up;
    logic    r_out_down;
    t_duty   r_out_duty;
    t_cmp    r_out_cmp;
    t_reason r_out_reason;

    t_adc    w_span;
    t_duty   w_up_quot;
    t_duty   w_dn_quot;
    logic    w_up_done;
    logic    w_dn_done;
    logic [PERW-1:0] w_cmp_quot;
    logic    w_cmp_done;

    t_duty   w_up_cmd;
    t_duty   w_dn_cmd;
    logic    w_sel_up;
    logic    w_sel_dn;
    logic    w_go_up;
    logic    w_go_dn;
    t_reason w_reason;
    t_duty   w_target;
    t_duty   w_cap;
    logic [DUTY_W:0] w_hi;
    logic [DUTY_W:0] w_tps;
    logic [DUTY_W:0] w_n;
    t_duty   w_duty;
    logic    w_in_acc;
    logic    w_out_free;

    assign w_span     = ADC_FULL - r_pad_deadzone;
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    ppmdl_lane #(.AW(ADC_W), .BW(DUTY_W), .DW(ADC_W), .QW(DUTY_W)) u_up_lane (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_pad_start),
        .i_mcand  (r_up_diff),
        .i_mplier (r_max_duty),
        .i_div    (w_span),
        .o_quot   (w_up_quot),
        .o_done   (w_up_done)
    );

    ppmdl_lane #(.AW(ADC_W), .BW(DUTY_W), .DW(ADC_W), .QW(DUTY_W)) u_dn_lane (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_pad_start),
        .i_mcand  (r_dn_diff),
        .i_mplier (r_max_duty),
        .i_div    (w_span),
        .o_quot   (w_dn_quot),
        .o_done   (w_dn_done)
    );

    ppmdl_lane #(.AW(DUTY_W), .BW(PERW), .DW(DUTY_W), .QW(PERW)) u_cmp_lane (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_cmp_start),
        .i_mcand  (r_duty),
        .i_mplier (PERW'(PWM_PERIOD_TICKS)),
        .i_div    (DUTY_FULL),
        .o_quot   (w_cmp_quot),
        .o_done   (w_cmp_done)
    );

    always_comb begin
        w_up_cmd = (r_pad_deadzone == ADC_FULL) ? '0 : w_up_quot;
        w_dn_cmd = (r_pad_deadzone == ADC_FULL) ? '0 : w_dn_quot;

        w_sel_up = (w_up_cmd > w_dn_cmd) && (w_up_cmd > r_min_command)
                   && (r_dn_raw <= r_other_pad_idle);
        w_sel_dn = !w_sel_up && (w_dn_cmd > w_up_cmd) && (w_dn_cmd > r_min_command)
                   && (r_up_raw <= r_other_pad_idle);
        w_target = w_sel_up ? w_up_cmd : w_dn_cmd;

        w_go_up  = w_sel_up;
        w_go_dn  = w_sel_dn;
        w_reason = STOP_NONE;
        if (w_sel_up && (r_pos >= r_upper_limit)) begin
            w_go_up  = 1'b0;
            w_reason = STOP_UPPER;
        end
        if (w_sel_dn && (r_pos <= r_lower_limit)) begin
            w_go_dn  = 1'b0;
            w_reason = STOP_LOWER;
        end
        if (r_cur >= r_overcurrent_level) begin
            w_go_up  = 1'b0;
            w_go_dn  = 1'b0;
            w_reason = STOP_OVERCURRENT;
        end

        w_cap = (r_max_duty > DUTY_FULL) ? DUTY_FULL : r_max_duty;
        w_hi  = {1'b0, r_held_duty} + {1'b0, r_ramp_step};
        w_tps = {1'b0, w_target} + {1'b0, r_ramp_step};
        if ({1'b0, w_target} > w_hi) begin
            w_n = w_hi;
        end else if (w_tps < {1'b0, r_held_duty}) begin
            w_n = {1'b0, r_held_duty - r_ramp_step};
        end else begin
            w_n = {1'b0, w_target};
        end
        if (!(w_go_up || w_go_dn)) begin
            w_duty = '0;
        end else if (w_n > {1'b0, w_cap}) begin
            w_duty = w_cap;
        end else begin
            w_duty = w_n[DUTY_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower_limit       <= RST_LOWER_LIMIT;
            r_upper_limit       <= RST_UPPER_LIMIT;
            r_pad_deadzone      <= RST_PAD_DEADZONE;
            r_other_pad_idle    <= RST_OTHER_PAD_IDLE;
            r_overcurrent_level <= RST_OVERCURRENT_LEVEL;
            r_max_duty          <= RST_MAX_DUTY;
            r_ramp_step         <= RST_RAMP_STEP;
            r_min_command       <= RST_MIN_COMMAND;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LOWER_LIMIT:       r_lower_limit       <= i_cfg_data[ADC_W-1:0];
                REG_UPPER_LIMIT:       r_upper_limit       <= i_cfg_data[ADC_W-1:0];
                REG_PAD_DEADZONE:      r_pad_deadzone      <= i_cfg_data[ADC_W-1:0];
                REG_OTHER_PAD_IDLE:    r_other_pad_idle    <= i_cfg_data[ADC_W-1:0];
                REG_OVERCURRENT_LEVEL: r_overcurrent_level <= i_cfg_data[ADC_W-1:0];
                REG_MAX_DUTY:          r_max_duty          <= i_cfg_data[DUTY_W-1:0];
                REG_RAMP_STEP:         r_ramp_step         <= i_cfg_data[DUTY_W-1:0];
                REG_MIN_COMMAND:       r_min_command       <= i_cfg_data[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pad_start <= 1'b0;
            r_cmp_start <= 1'b0;
            r_held_duty <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pad_start <= w_in_acc;
            r_cmp_start <= (r_state == S_ARB);
            if ((r_state == S_WAIT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_up_raw    <= i_in.up_pressure;
                        r_dn_raw    <= i_in.down_pressure;
                        r_pos       <= i_in.arm_position;
                        r_cur       <= i_in.motor_current;
                        r_up_diff   <= (i_in.up_pressure > r_pad_deadzone)
                                       ? (i_in.up_pressure - r_pad_deadzone) : '0;
                        r_dn_diff   <= (i_in.down_pressure > r_pad_deadzone)
                                       ? (i_in.down_pressure - r_pad_deadzone) : '0;
                        r_state     <= S_CMD;
                    end
                end
                S_CMD: begin
                    if (w_up_done) begin
                        r_state <= S_ARB;
                    end
                end
                S_ARB: begin
                    r_go_up     <= w_go_up;
                    r_go_down   <= w_go_dn;
                    r_reason    <= w_reason;
                    r_duty      <= w_duty;
                    r_held_duty <= w_duty;
                    r_state     <= S_PWM;
                end
                S_PWM: begin
                    if (w_cmp_done) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (w_out_free) begin
                        r_out_up     <= r_go_up;
                        r_out_down   <= r_go_down;
                        r_out_duty   <= r_duty;
                        r_out_cmp    <= CMP_W'(w_cmp_quot);
                        r_out_reason <= r_reason;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.drive_up      = r_out_up;
    assign o_out.drive_down    = r_out_down;
    assign o_out.duty_level    = r_out_duty;
    assign o_out.pwm_compare   = r_out_cmp;
    assign o_out.stop_reason   = r_out_reason;

`ifndef SYNTHESIS
    a_one_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.drive_up && o_out.drive_down))
        else $error("both bridge directions driven");
    a_lanes_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_up_done == w_dn_done)
        else $error("pad lanes out of step");
    a_held_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_duty <= DUTY_FULL)
        else $error("held duty above full scale");
    a_duty_needs_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.duty_level != '0))
        |-> (o_out.drive_up || o_out.drive_down))
        else $error("duty without direction");
`endif

endmodule

// ----- rtl/ppmdl_lane.sv -----
// ----------------------------------------------------------------------------
// ppmdl_lane
// Bit-serial multiply then divide: quot = floor(mcand * mplier / div).
// Shift-add over the multiplier bits, then restoring division one quotient
// bit per cycle. The quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module ppmdl_lane #(
    parameter int AW = 12,
    parameter int BW = 15,
    parameter int DW = 12,
    parameter int QW = 15
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [AW-1:0] i_mcand,
    input  logic [BW-1:0] i_mplier,
    input  logic [DW-1:0] i_div,
    output logic [QW-1:0] o_quot,
    output logic          o_done
);
    localparam int PW    = AW + BW;
    localparam int NMAX  = (BW > QW) ? BW : QW;
    localparam int CNTW  = $clog2(NMAX + 1);

    typedef enum logic [1:0] {L_IDLE, L_MUL, L_DIV} t_lane_state;

    t_lane_state   r_state;
    logic [CNTW-1:0] r_cnt;
    logic [PW-1:0] r_acc;
    logic [PW-1:0] r_mcand;
    logic [BW-1:0] r_mplier;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_quo;
    logic          r_done;

    logic [PW-1:0] n_acc;
    logic [DW:0]   w_trial;
    logic [DW:0]   w_sub;
    logic          w_ge;

    always_comb begin
        n_acc   = r_mplier[0] ? (r_acc + r_mcand) : r_acc;
        w_trial = {r_rem, r_quo[QW-1]};
        w_ge    = (w_trial >= {1'b0, i_div});
        w_sub   = w_trial - {1'b0, i_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == L_DIV) && (r_cnt == CNTW'(QW - 1));
            case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_acc    <= '0;
                        r_mcand  <= PW'(i_mcand);
                        r_mplier <= i_mplier;
                        r_cnt    <= '0;
                        r_state  <= L_MUL;
                    end
                end
                L_MUL: begin
                    r_acc    <= n_acc;
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    if (r_cnt == CNTW'(BW - 1)) begin
                        r_rem   <= DW'(n_acc[PW-1:QW]);
                        r_quo   <= n_acc[QW-1:0];
                        r_cnt   <= '0;
                        r_state <= L_DIV;
                    end else begin
                        r_cnt   <= r_cnt + 1'b1;
                    end
                end
                L_DIV: begin
                    r_rem <= w_ge ? w_sub[DW-1:0] : w_trial[DW-1:0];
                    r_quo <= {r_quo[QW-2:0], w_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNTW'(QW - 1)) begin
                        r_state <= L_IDLE;
                    end
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_quot = r_quo;
    assign o_done = r_done;

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("lane done held longer than one cycle");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == L_IDLE))
        else $error("lane started while busy");
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == L_DIV) |-> (r_cnt < CNTW'(QW)))
        else $error("lane divide count out of range");
`endif

endmodule

// ----- tb/pressure_pad_motor_drive_limiter_tb.sv -----
// ----------------------------------------------------------------------------
// pressure_pad_motor_drive_limiter_tb
// Self-checking bench for the pressure-pad motor drive limiter. Sample beats
// go in with random gaps and result beats come out under random back
// pressure. A scoreboard works out each expected drive beat from its own copy
// of the registers and the held duty and checks every field of each result in
// order. A directed set of samples covers the pad, limit, overcurrent, ramp
// and cap corner cases. Random register settings follow, each with press runs
// in one direction plus noise beats.
// ----------------------------------------------------------------------------
module pressure_pad_motor_drive_limiter_tb;
    import ppmdl_pkg::*;

    localparam int PWM_TICKS   = 500;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE      = 120;

    typedef struct packed {
        t_adc up_pressure;
        t_adc down_pressure;
        t_adc arm_position;
        t_adc motor_current;
    } pad_sample_t;

    typedef struct packed {
        logic    drive_up;
        logic    drive_down;
        t_duty   duty_level;
        t_cmp    pwm_compare;
        t_reason stop_reason;
    } drive_cmd_t;

    class drive_scoreboard;
        int unsigned lower_limit;
        int unsigned upper_limit;
        int unsigned pad_deadzone;
        int unsigned other_pad_idle;
        int unsigned overcurrent_level;
        int unsigned max_duty;
        int unsigned ramp_step;
        int unsigned min_command;
        int unsigned held_duty;
        int unsigned pwm_period;
        drive_cmd_t  pending_drives[$];
        int          errors;

        function new(int unsigned period);
            pwm_period        = period;
            errors            = 0;
            lower_limit       = RST_LOWER_LIMIT;
            upper_limit       = RST_UPPER_LIMIT;
            pad_deadzone      = RST_PAD_DEADZONE;
            other_pad_idle    = RST_OTHER_PAD_IDLE;
            overcurrent_level = RST_OVERCURRENT_LEVEL;
            max_duty          = RST_MAX_DUTY;
            ramp_step         = RST_RAMP_STEP;
            min_command       = RST_MIN_COMMAND;
            held_duty         = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, t_cfg_data data);
            case (idx)
                REG_LOWER_LIMIT:       lower_limit       = data[ADC_W-1:0];
                REG_UPPER_LIMIT:       upper_limit       = data[ADC_W-1:0];
                REG_PAD_DEADZONE:      pad_deadzone      = data[ADC_W-1:0];
                REG_OTHER_PAD_IDLE:    other_pad_idle    = data[ADC_W-1:0];
                REG_OVERCURRENT_LEVEL: overcurrent_level = data[ADC_W-1:0];
                REG_MAX_DUTY:          max_duty          = data;
                REG_RAMP_STEP:         ramp_step         = data;
                REG_MIN_COMMAND:       min_command       = data;
                default: ;
            endcase
        endfunction

        function int unsigned pad_command(t_adc raw);
            int unsigned r;
            int unsigned span;
            r = raw;
            if (r <= pad_deadzone) return 0;
            span = ADC_FULL - pad_deadzone;
            if (span == 0) return 0;
            return ((r - pad_deadzone) * max_duty) / span;
        endfunction

        function drive_cmd_t drive_for(pad_sample_t s);
            drive_cmd_t  d;
            int unsigned up_c;
            int unsigned dn_c;
            int unsigned cap;
            int unsigned target;
            int unsigned duty;
            int          h;
            int          st;
            int          n;
            bit          go_up;
            bit          go_dn;
            t_reason     why;
            up_c   = pad_command(s.up_pressure);
            dn_c   = pad_command(s.down_pressure);
            cap    = (max_duty > DUTY_FULL) ? DUTY_FULL : max_duty;
            go_up  = 1'b0;
            go_dn  = 1'b0;
            target = 0;
            duty   = 0;
            why    = STOP_NONE;
            if (up_c > dn_c && up_c > min_command && s.down_pressure <= other_pad_idle) begin
                go_up  = 1'b1;
                target = up_c;
            end else if (dn_c > up_c && dn_c > min_command
                         && s.up_pressure <= other_pad_idle) begin
                go_dn  = 1'b1;
                target = dn_c;
            end
            if (go_up && s.arm_position >= upper_limit) begin
                go_up = 1'b0;
                why   = STOP_UPPER;
            end
            if (go_dn && s.arm_position <= lower_limit) begin
                go_dn = 1'b0;
                why   = STOP_LOWER;
            end
            if (s.motor_current >= overcurrent_level) begin
                go_up = 1'b0;
                go_dn = 1'b0;
                why   = STOP_OVERCURRENT;
            end
            if (go_up || go_dn) begin
                h  = held_duty;
                st = ramp_step;
                if (int'(target) > h + st) n = h + st;
                else if (int'(target) < h - st) n = h - st;
                else n = target;
                if (n < 0) n = 0;
                if (n > int'(cap)) n = cap;
                duty = n;
            end
            held_duty       = duty & 32'h7FFF;
            d.drive_up      = go_up;
            d.drive_down    = go_dn;
            d.duty_level    = t_duty'(duty);
            d.pwm_compare   = t_cmp'((duty * pwm_period) / DUTY_FULL);
            d.stop_reason   = why;
            return d;
        endfunction

        function void note_sample(pad_sample_t s);
            pending_drives.push_back(drive_for(s));
        endfunction

        function int outstanding();
            return pending_drives.size();
        endfunction

        task report_mismatch(string field, logic [15:0] got, logic [15:0] want);
            errors++;
            if (errors <= 40)
                $display("mismatch on %s: got %0d, want %0d", field, got, want);
        endtask

        task check_drive(drive_cmd_t got);
            drive_cmd_t want;
            if (pending_drives.size() == 0) begin
                report_mismatch("unexpected drive beat", 1, 0);
                return;
            end
            want = pending_drives.pop_front();
            if (got.drive_up !== want.drive_up)
                report_mismatch("drive_up", got.drive_up, want.drive_up);
            if (got.drive_down !== want.drive_down)
                report_mismatch("drive_down", got.drive_down, want.drive_down);
            if (got.duty_level !== want.duty_level)
                report_mismatch("duty_level", got.duty_level, want.duty_level);
            if (got.pwm_compare !== want.pwm_compare)
                report_mismatch("pwm_compare", got.pwm_compare, want.pwm_compare);
            if (got.stop_reason !== want.stop_reason)
                report_mismatch("stop_reason", got.stop_reason, want.stop_reason);
        endtask
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    t_cfg_idx        i_cfg_idx;
    t_cfg_data       i_cfg_data;
    bit              calm;
    int              quiet_cycles;
    drive_scoreboard sb;

    ppmdl_in_if  in_ch ();
    ppmdl_out_if out_ch ();

    pressure_pad_motor_drive_limiter #(
        .PWM_PERIOD_TICKS (PWM_TICKS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // result side back pressure
    initial begin
        int hold;
        out_ch.ready = 1'b0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                out_ch.ready = 1'b0;
                hold = $urandom_range(0, 14);
            end else begin
                out_ch.ready = 1'b1;
                hold = $urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(20, 120);
            end
        end
    end

    always @(posedge i_clk) begin
        drive_cmd_t got;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got.drive_up      = out_ch.drive_up;
            got.drive_down    = out_ch.drive_down;
            got.duty_level    = out_ch.duty_level;
            got.pwm_compare   = out_ch.pwm_compare;
            got.stop_reason   = out_ch.stop_reason;
            sb.check_drive(got);
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("pressure_pad_motor_drive_limiter test failed");
        $finish;
    end

    function automatic pad_sample_t sample_of(int unsigned up, int unsigned dn,
                                              int unsigned pos, int unsigned cur);
        pad_sample_t s;
        s.up_pressure   = t_adc'(up);
        s.down_pressure = t_adc'(dn);
        s.arm_position  = t_adc'(pos);
        s.motor_current = t_adc'(cur);
        return s;
    endfunction

    function automatic pad_sample_t noise_sample();
        return sample_of($urandom_range(0, 4095), $urandom_range(0, 4095),
                         $urandom_range(0, 4095), $urandom_range(0, 4095));
    endfunction

    // one beat of a press run: one pad pressed, the other mostly at rest, mostly inside limits
    function automatic pad_sample_t pressed_sample(bit up_dir);
        int unsigned press_v;
        int unsigned rest_v;
        int unsigned pos;
        int unsigned cur;
        press_v = (sb.pad_deadzone >= 4095) ? 4095 : $urandom_range(sb.pad_deadzone + 1, 4095);
        if ($urandom_range(0, 3) == 0) press_v = $urandom_range(3600, 4095);
        rest_v = $urandom_range(0, sb.other_pad_idle);
        if ($urandom_range(0, 7) == 0) rest_v = $urandom_range(0, 4095);
        pos = $urandom_range(0, 4095);
        if (sb.lower_limit + 1 < sb.upper_limit && $urandom_range(0, 9) != 0)
            pos = $urandom_range(sb.lower_limit + 1, sb.upper_limit - 1);
        cur = $urandom_range(0, 4095);
        if (sb.overcurrent_level > 0 && $urandom_range(0, 9) != 0)
            cur = $urandom_range(0, sb.overcurrent_level - 1);
        if (up_dir) return sample_of(press_v, rest_v, pos, cur);
        return sample_of(rest_v, press_v, pos, cur);
    endfunction

    function automatic int unsigned pick(int unsigned lo, int unsigned hi,
                                         int unsigned edge_lo, int unsigned edge_hi);
        case ($urandom_range(0, 9))
            0:       return edge_lo;
            1:       return edge_hi;
            default: return $urandom_range(lo, hi);
        endcase
    endfunction

    task automatic send_sample(pad_sample_t s);
        int gap;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_ch.valid = 1'b0;
            gap = $urandom_range(1, 15);
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid         = 1'b1;
        in_ch.up_pressure   = s.up_pressure;
        in_ch.down_pressure = s.down_pressure;
        in_ch.arm_position  = s.arm_position;
        in_ch.motor_current = s.motor_current;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_sample(s);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int unsigned data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = t_cfg_data'(data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_reg(idx, t_cfg_data'(data));
    endtask

    task automatic load_settings(int unsigned lo, int unsigned hi, int unsigned dz,
                                 int unsigned idle, int unsigned oc, int unsigned maxd,
                                 int unsigned ramp, int unsigned minc);
        wait_drained();
        write_reg(REG_LOWER_LIMIT, lo);
        write_reg(REG_UPPER_LIMIT, hi);
        write_reg(REG_PAD_DEADZONE, dz);
        write_reg(REG_OTHER_PAD_IDLE, idle);
        write_reg(REG_OVERCURRENT_LEVEL, oc);
        write_reg(REG_MAX_DUTY, maxd);
        write_reg(REG_RAMP_STEP, ramp);
        write_reg(REG_MIN_COMMAND, minc);
    endtask

    task automatic random_settings();
        load_settings(pick(0, 1800, 0, 4095), pick(2200, 4095, 0, 4095),
                      pick(0, 1000, 0, 4095), pick(0, 500, 0, 4095),
                      pick(300, 4095, 0, 4095), pick(1000, 25600, 0, 32767),
                      pick(1, 4000, 0, 25600), pick(0, 3000, 0, 25600));
    endtask

    task automatic run_phase(int unsigned beats);
        int unsigned sent;
        int unsigned run_len;
        bit          up_dir;
        sent = 0;
        while (sent < beats) begin
            if ($urandom_range(0, 9) < 7) begin
                up_dir  = $urandom_range(0, 1);
                run_len = $urandom_range(3, 25);
                if (run_len > beats - sent) run_len = beats - sent;
                repeat (run_len) begin
                    send_sample(pressed_sample(up_dir));
                    sent++;
                end
            end else begin
                send_sample(noise_sample());
                sent++;
            end
        end
    endtask

    initial begin
        sb                  = new(PWM_TICKS);
        calm                = 1'b0;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = REG_LOWER_LIMIT;
        i_cfg_data          = '0;
        in_ch.valid         = 1'b0;
        in_ch.up_pressure   = '0;
        in_ch.down_pressure = '0;
        in_ch.arm_position  = '0;
        in_ch.motor_current = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: pads, idle opposite pad, limits, overcurrent, ramp
        send_sample(sample_of(0, 0, 0, 0));
        send_sample(sample_of(4095, 4095, 4095, 4095));
        send_sample(sample_of(4095, 0, 2000, 0));
        send_sample(sample_of(4095, 0, 2000, 0));
        send_sample(sample_of(4095, 100, 2000, 804));
        send_sample(sample_of(4095, 101, 2000, 0));
        send_sample(sample_of(200, 0, 2000, 0));
        send_sample(sample_of(201, 0, 2000, 0));
        send_sample(sample_of(0, 4095, 2000, 0));
        send_sample(sample_of(100, 4095, 2000, 0));
        send_sample(sample_of(0, 4095, 600, 0));
        send_sample(sample_of(0, 4095, 601, 0));
        send_sample(sample_of(4095, 0, 3500, 0));
        send_sample(sample_of(4095, 0, 3499, 0));
        send_sample(sample_of(4095, 0, 2000, 805));
        send_sample(sample_of(0, 0, 2000, 4095));
        send_sample(sample_of(3000, 3000, 2000, 0));
        send_sample(sample_of(4095, 0, 4095, 4095));

        // zero span
        load_settings(600, 3500, 4095, 100, 805, 12800, 512, 128);
        send_sample(sample_of(4095, 0, 2000, 0));
        send_sample(sample_of(0, 4095, 2000, 0));

        // duty cap above full scale, full-size ramp
        load_settings(0, 4095, 0, 0, 4095, 32767, 25600, 0);
        send_sample(sample_of(4095, 0, 2000, 0));
        send_sample(sample_of(2048, 0, 2000, 0));
        send_sample(sample_of(0, 4095, 1, 0));

        load_settings(0, 0, 0, 0, 0, 0, 0, 0);
        send_sample(sample_of(4095, 0, 2000, 0));
        send_sample(sample_of(0, 0, 0, 0));

        load_settings(4095, 4095, 4095, 4095, 4095, 25600, 25600, 25600);
        send_sample(sample_of(4095, 4095, 4095, 4094));

        // moving with no ramp allowance
        load_settings(600, 3500, 200, 100, 805, 12800, 0, 128);
        send_sample(sample_of(4095, 0, 2000, 0));

        for (int ph = 0; ph < 10; ph++) begin
            random_settings();
            run_phase(30);
            if (ph == 4) wait_drained();
            run_phase(30);
        end

        random_settings();
        calm = 1'b1;
        run_phase(120);

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("pressure_pad_motor_drive_limiter test passed");
        else
            $display("pressure_pad_motor_drive_limiter test failed");
        $finish;
    end

endmodule
